[hw/rtl/clipped_sgd_weight_update_unit_assert.svh]
// assertion macros for the clipped sgd weight update unit
// expects clk_i and rst_ni in the scope of the including module
`ifndef CLIPPED_SGD_WEIGHT_UPDATE_UNIT_ASSERT_SVH
`define CLIPPED_SGD_WEIGHT_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication
`define CSGD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csgd: same-cycle check failed");

// next-cycle implication
`define CSGD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csgd: next-cycle check failed");

`endif

[hw/rtl/csgd_pkg.sv]
// types and constants shared by the clipped sgd weight update unit
// no dependencies
`default_nettype none

package csgd_pkg;

  // request kinds carried in tuser
  typedef enum logic [2:0] {
    REQ_WRITE = 3'd0,
    REQ_ADD   = 3'd1,
    REQ_APPLY = 3'd2,
    REQ_READ  = 3'd3,
    REQ_CLEAR = 3'd4
  } req_e;

  // result status
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_RANGE  = 2'd1,
    STAT_LOCKED = 2'd2
  } status_e;

  // configuration register indexes
  localparam logic [1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [1:0] CFG_BATCH      = 2'd1;
  localparam logic [1:0] CFG_ELEMS      = 2'd2;
  localparam logic [1:0] CFG_LOCK       = 2'd3;

  // control sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  localparam int SUM_W      = 24;
  localparam int BATCH_W    = 7;
  localparam int LR_W       = 20;
  localparam int BATCH_MAX  = 64;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = SUM_W / DIV_BITS;

  localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
  localparam logic signed [31:0] NEG_ONE_Q16 = -32'sd65536;
  localparam logic signed [25:0] SUM_MAX     = 26'sd8388607;
  localparam logic signed [25:0] SUM_MIN     = -26'sd8388608;
  localparam logic signed [33:0] W_MAX       = 34'sd2147483647;
  localparam logic signed [33:0] W_MIN       = -34'sd2147483648;

  // write strobes toward the state memories
  typedef struct packed {
    logic wgt_we;
    logic sum_we;
  } store_ctl_t;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [BATCH_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/csgd_div.sv]
// iterative unsigned divider, four quotient bits per cycle
// depends on csgd_pkg
`default_nettype none

module csgd_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire csgd_pkg::div_req_t req_i,
  output csgd_pkg::div_rsp_t      rsp_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [2:0]                      cnt_q;
  logic [csgd_pkg::BATCH_W-1:0]    rem_q;
  logic [csgd_pkg::BATCH_W-1:0]    rem_d;
  logic [csgd_pkg::SUM_W-1:0]      dq_q;
  logic [csgd_pkg::SUM_W-1:0]      dq_d;
  logic [csgd_pkg::BATCH_W-1:0]    dvs_q;

  // four restoring steps on the shifting dividend / quotient word
  always_comb begin
    logic [csgd_pkg::BATCH_W:0] trial;
    rem_d = rem_q;
    dq_d  = dq_q;
    for (int k = 0; k < csgd_pkg::DIV_BITS; k++) begin
      trial = {rem_d, dq_d[csgd_pkg::SUM_W-1]};
      dq_d  = {dq_d[csgd_pkg::SUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d    = csgd_pkg::BATCH_W'(trial - {1'b0, dvs_q});
        dq_d[0]  = 1'b1;
      end else begin
        rem_d    = trial[csgd_pkg::BATCH_W-1:0];
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 3'(csgd_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dq_q  <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dq_q;

endmodule

`default_nettype wire

[hw/rtl/csgd_store.sv]
// weight and gradient-sum memories with the clearing pass after reset
// depends on csgd_pkg
`default_nettype none

module csgd_store #(
  parameter int ELEMENTS = 1024,
  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [AW-1:0]                 rd_addr_i,
  input  wire logic [AW-1:0]                 wr_addr_i,
  input  wire csgd_pkg::store_ctl_t          ctl_i,
  input  wire logic [31:0]                   wgt_wdata_i,
  input  wire logic [csgd_pkg::SUM_W-1:0]    sum_wdata_i,
  output logic      [31:0]                   wgt_rdata_o,
  output logic      [csgd_pkg::SUM_W-1:0]    sum_rdata_o,
  output logic                               busy_o
);

  logic [31:0]               wgt_mem [ELEMENTS];
  logic [csgd_pkg::SUM_W-1:0] sum_mem [ELEMENTS];
  logic [31:0]               wgt_rd_q;
  logic [csgd_pkg::SUM_W-1:0] sum_rd_q;
  logic                      busy_q;
  logic [AW-1:0]             clr_cnt_q;

  // clearing pass over the sum memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else if (busy_q) begin
      if (clr_cnt_q == AW'(ELEMENTS - 1)) begin
        busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  // weight memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.wgt_we) begin
      wgt_mem[wr_addr_i] <= wgt_wdata_i;
    end
    wgt_rd_q <= wgt_mem[rd_addr_i];
  end

  // gradient-sum memory
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      sum_mem[clr_cnt_q] <= '0;
    end else if (ctl_i.sum_we) begin
      sum_mem[wr_addr_i] <= sum_wdata_i;
    end
    sum_rd_q <= sum_mem[rd_addr_i];
  end

  assign wgt_rdata_o = wgt_rd_q;
  assign sum_rdata_o = sum_rd_q;
  assign busy_o      = busy_q;

endmodule

`default_nettype wire

[hw/rtl/clipped_sgd_weight_update_unit.sv]
// top level of the clipped sgd weight update unit: sequencer, arithmetic, ports
// depends on csgd_pkg, csgd_store, csgd_div and the assertion macro header
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: elem_index, data_value; tuser: req_type
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: weight_value; tuser: status
// cfg       in   cfg_we_i                       cfg_idx_i, cfg_data_i
//
// write, add, read, clear, locked apply and out-of-range requests go from accept through the
// read and done states to the result register. other apply requests run memory read, divider
// (six 4-bit steps and the done flag), multiply, writeback, result; after the result the
// sequencer returns to idle before the next accept. one request is in work at a time; the
// result register lets the next request in while the previous result waits for m_axis_tready.
// after reset the sum memory is cleared one entry a cycle over all ELEMENTS, with s_axis_tready low.
`default_nettype none

module clipped_sgd_weight_update_unit #(
  parameter int ELEMENTS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // [9:0] elem_index, [41:10] data_value, rest zero
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] req_type
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] weight_value
  output logic [1:0]       m_axis_tuser,   // [1:0] status
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [19:0] cfg_data_i
);

  `include "clipped_sgd_weight_update_unit_assert.svh"

  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  // configuration registers
  logic [csgd_pkg::LR_W-1:0]    lr_q;
  logic [csgd_pkg::BATCH_W-1:0] batch_q;
  logic [10:0]                  elems_q;
  logic                         lock_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q    <= 20'd655;
      batch_q <= 7'd1;
      elems_q <= 11'd1024;
      lock_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        csgd_pkg::CFG_LEARN_RATE: lr_q    <= cfg_data_i;
        csgd_pkg::CFG_BATCH:      batch_q <= cfg_data_i[csgd_pkg::BATCH_W-1:0];
        csgd_pkg::CFG_ELEMS:      elems_q <= cfg_data_i[10:0];
        csgd_pkg::CFG_LOCK:       lock_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // request fields
  logic [9:0]         in_idx;
  logic signed [31:0] in_data;
  logic               in_rng;
  logic               s_acc;

  assign in_idx  = s_axis_tdata[9:0];
  assign in_data = s_axis_tdata[41:10];
  assign in_rng  = (11'(in_idx) < elems_q) && (32'(in_idx) < ELEMENTS);

  // sequencer and work registers
  csgd_pkg::state_e           state_q, state_d;
  logic [2:0]                 req_q;
  logic [9:0]                 idx_q;
  logic signed [31:0]         data_q;
  logic                       rng_q;
  logic signed [31:0]         wgt_q;
  logic                       neg_q;
  logic [csgd_pkg::SUM_W-1:0] qmag_q;
  logic [43:0]                prod_q;
  logic [31:0]                res_data_q;
  csgd_pkg::status_e          res_stat_q;
  logic                       out_valid_q;
  logic [31:0]                out_data_q;
  csgd_pkg::status_e          out_stat_q;

  // memory and divider links
  csgd_pkg::store_ctl_t       store_ctl;
  logic [31:0]                wgt_wdata;
  logic [csgd_pkg::SUM_W-1:0] sum_wdata;
  logic signed [31:0]         wgt_rd;
  logic signed [csgd_pkg::SUM_W-1:0] sum_rd;
  logic                       clr_busy;
  csgd_pkg::div_req_t         div_req;
  csgd_pkg::div_rsp_t         div_rsp;

  assign s_axis_tready = (state_q == csgd_pkg::ST_IDLE) && !clr_busy;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  csgd_store #(
    .ELEMENTS (ELEMENTS)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_addr_i   (AW'(in_idx)),
    .wr_addr_i   (AW'(idx_q)),
    .ctl_i       (store_ctl),
    .wgt_wdata_i (wgt_wdata),
    .sum_wdata_i (sum_wdata),
    .wgt_rdata_o (wgt_rd),
    .sum_rdata_o (sum_rd),
    .busy_o      (clr_busy)
  );

  csgd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // gradient clip and saturating accumulate
  logic signed [31:0] grad_clip;
  logic signed [25:0] sum_add;
  logic signed [25:0] sum_sat;

  always_comb begin
    if (data_q > csgd_pkg::ONE_Q16) begin
      grad_clip = csgd_pkg::ONE_Q16;
    end else if (data_q < csgd_pkg::NEG_ONE_Q16) begin
      grad_clip = csgd_pkg::NEG_ONE_Q16;
    end else begin
      grad_clip = data_q;
    end
    sum_add = 26'(sum_rd) + 26'(grad_clip);
    if (sum_add > csgd_pkg::SUM_MAX) begin
      sum_sat = csgd_pkg::SUM_MAX;
    end else if (sum_add < csgd_pkg::SUM_MIN) begin
      sum_sat = csgd_pkg::SUM_MIN;
    end else begin
      sum_sat = sum_add;
    end
  end

  // divider operands: magnitude of the sum and the clamped batch count
  logic [csgd_pkg::BATCH_W-1:0] batch_eff;
  logic [csgd_pkg::SUM_W-1:0]   sum_mag;

  always_comb begin
    if (batch_q == '0) begin
      batch_eff = csgd_pkg::BATCH_W'(1);
    end else if (32'(batch_q) > csgd_pkg::BATCH_MAX) begin
      batch_eff = csgd_pkg::BATCH_W'(csgd_pkg::BATCH_MAX);
    end else begin
      batch_eff = batch_q;
    end
    sum_mag = sum_rd[csgd_pkg::SUM_W-1] ? csgd_pkg::SUM_W'(-sum_rd) : csgd_pkg::SUM_W'(sum_rd);
  end

  // weight step and saturating subtract
  logic [27:0]        step;
  logic signed [33:0] new_w;
  logic signed [31:0] new_w_sat;

  always_comb begin
    step = prod_q[43:16];
    if (neg_q) begin
      new_w = 34'(wgt_q) + 34'(step);
    end else begin
      new_w = 34'(wgt_q) - 34'(step);
    end
    if (new_w > csgd_pkg::W_MAX) begin
      new_w_sat = 32'(csgd_pkg::W_MAX);
    end else if (new_w < csgd_pkg::W_MIN) begin
      new_w_sat = 32'(csgd_pkg::W_MIN);
    end else begin
      new_w_sat = 32'(new_w);
    end
  end

  // memory writes and divider start
  always_comb begin
    store_ctl        = '0;
    wgt_wdata        = data_q;
    sum_wdata        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = sum_mag;
    div_req.divisor  = batch_eff;
    if (state_q == csgd_pkg::ST_READ && rng_q) begin
      unique case (req_q)
        csgd_pkg::REQ_WRITE: store_ctl.wgt_we = 1'b1;
        csgd_pkg::REQ_ADD: begin
          store_ctl.sum_we = 1'b1;
          sum_wdata        = csgd_pkg::SUM_W'(sum_sat);
        end
        csgd_pkg::REQ_CLEAR: store_ctl.sum_we = 1'b1;
        csgd_pkg::REQ_APPLY: div_req.start = !lock_q;
        default: ;
      endcase
    end else if (state_q == csgd_pkg::ST_UPD) begin
      store_ctl.wgt_we = 1'b1;
      wgt_wdata        = new_w_sat;
    end
  end

  // next state
  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csgd_pkg::ST_IDLE: if (s_acc) state_d = csgd_pkg::ST_READ;
      csgd_pkg::ST_READ: begin
        if (div_req.start) begin
          state_d = csgd_pkg::ST_DIV;
        end else begin
          state_d = csgd_pkg::ST_DONE;
        end
      end
      csgd_pkg::ST_DIV:  if (div_rsp.done) state_d = csgd_pkg::ST_MUL;
      csgd_pkg::ST_MUL:  state_d = csgd_pkg::ST_UPD;
      csgd_pkg::ST_UPD:  state_d = csgd_pkg::ST_DONE;
      csgd_pkg::ST_DONE: if (out_free) state_d = csgd_pkg::ST_IDLE;
      default:           state_d = csgd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csgd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // work registers and result
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      req_q  <= s_axis_tuser;
      idx_q  <= in_idx;
      data_q <= in_data;
      rng_q  <= in_rng;
    end
    if (state_q == csgd_pkg::ST_READ) begin
      wgt_q <= wgt_rd;
      neg_q <= sum_rd[csgd_pkg::SUM_W-1];
      if (!rng_q && req_q <= csgd_pkg::REQ_CLEAR) begin
        res_data_q <= '0;
        res_stat_q <= csgd_pkg::STAT_RANGE;
      end else begin
        unique case (req_q) inside
          csgd_pkg::REQ_WRITE: begin
            res_data_q <= data_q;
            res_stat_q <= csgd_pkg::STAT_OK;
          end
          csgd_pkg::REQ_APPLY: begin
            res_data_q <= wgt_rd;
            if (lock_q) begin
              res_stat_q <= csgd_pkg::STAT_LOCKED;
            end else begin
              res_stat_q <= csgd_pkg::STAT_OK;
            end
          end
          csgd_pkg::REQ_ADD, csgd_pkg::REQ_READ, csgd_pkg::REQ_CLEAR: begin
            res_data_q <= wgt_rd;
            res_stat_q <= csgd_pkg::STAT_OK;
          end
          default: begin
            res_data_q <= '0;
            res_stat_q <= csgd_pkg::STAT_OK;
          end
        endcase
      end
    end
    if (state_q == csgd_pkg::ST_DIV && div_rsp.done) begin
      qmag_q <= div_rsp.quotient;
    end
    if (state_q == csgd_pkg::ST_MUL) begin
      prod_q <= 44'(qmag_q) * 44'(lr_q);
    end
    if (state_q == csgd_pkg::ST_UPD) begin
      res_data_q <= new_w_sat;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == csgd_pkg::ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == csgd_pkg::ST_DONE && out_free) begin
      out_data_q <= res_data_q;
      out_stat_q <= res_stat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

  // checks
  `CSGD_ASSERT_NEXT(a_accept_to_read, s_acc, state_q == csgd_pkg::ST_READ)
  `CSGD_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state_q == csgd_pkg::ST_DIV)
  `CSGD_ASSERT_NOW(a_no_write_in_clear, store_ctl.wgt_we || store_ctl.sum_we, !clr_busy)
  `CSGD_ASSERT_NEXT(a_done_loads_out, state_q == csgd_pkg::ST_DONE && out_free, out_valid_q)

endmodule

`default_nettype wire
